// ----- rtl/pid_with_deadband_filtered_derivative_macros.svh -----
// Assertion macros for the PID controller block.
// Used by pid_dbfd_div and pid_with_deadband_filtered_derivative; needs nothing else.
`ifndef PID_WITH_DEADBAND_FILTERED_DERIVATIVE_MACROS_SVH
`define PID_WITH_DEADBAND_FILTERED_DERIVATIVE_MACROS_SVH

// Clocked check, off while reset is asserted.
`define PID_DBFD_ASSERT(name, clk, rst_n, prop, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error(msg);

// Clocked check, also active during reset.
`define PID_DBFD_ASSERT_ALWAYS(name, clk, prop, msg) \
  name: assert property (@(posedge clk) (prop)) \
    else $error(msg);

`endif

// ----- rtl/pid_dbfd_pkg.sv -----
// Shared types and constants for the PID controller block.
// Used by pid_dbfd_div and the top level; depends on nothing.
`default_nettype none

package pid_dbfd_pkg;

  localparam int ALPHA_Q16     = 19661;
  localparam int Q16_ONE       = 65536;
  localparam int MS_PER_S      = 1000;
  localparam int DIV_STEP_BITS = 2;

  localparam int DATA_W  = 32;
  localparam int DT_W    = 16;
  localparam int DVD_W   = 48;
  localparam int DVS_W   = 16;
  localparam int QUOT_W  = DVD_W + 1;
  localparam int PADDR_W = 5;

  localparam logic signed [31:0] DRIVE_MIN_RST = -32'sd11796480;
  localparam logic signed [31:0] DRIVE_MAX_RST = 32'sd11796480;
  localparam logic signed [31:0] ACCUM_MIN_RST = -32'sd6553600;
  localparam logic signed [31:0] ACCUM_MAX_RST = 32'sd6553600;

  typedef enum logic [2:0] {
    REG_GAIN_P    = 3'd0,
    REG_GAIN_I    = 3'd1,
    REG_GAIN_D    = 3'd2,
    REG_DRIVE_MIN = 3'd3,
    REG_DRIVE_MAX = 3'd4,
    REG_ACCUM_MIN = 3'd5,
    REG_ACCUM_MAX = 3'd6,
    REG_DEAD_ZONE = 3'd7
  } reg_idx_e;

  typedef struct packed {
    logic signed [31:0] target;
    logic signed [31:0] sensed;
    logic [15:0]        elapsed_ms;
    logic               restart;
  } in_item_t;

  typedef struct packed {
    logic signed [31:0] drive;
    logic signed [31:0] p_part;
    logic signed [31:0] i_part;
    logic signed [31:0] d_part;
    logic signed [31:0] last_err;
  } out_item_t;

  typedef struct packed {
    logic             start;
    logic             neg;
    logic [DVD_W-1:0] dividend;
    logic [DVS_W-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic                     busy;
    logic signed [QUOT_W-1:0] quot;
  } div_rsp_t;

endpackage

`default_nettype wire

// ----- rtl/pid_with_deadband_filtered_derivative.sv -----
// PID controller in signed Q16.16 with deadband, clamped integral and a
// low-pass filtered derivative. One item is taken, then the controller is busy
// until its result is loaded into the output register; the next item is taken
// while that result still waits. An item passes twice through the shared
// divider (error*dt/1000, then difference*1000/dt); the first item after
// reset or restart skips the divider. All products go through one shared
// 33x33 multiplier with a registered product.
// Depends on pid_dbfd_pkg, pid_dbfd_div and the block's assertion macros.
`default_nettype none
`include "pid_with_deadband_filtered_derivative_macros.svh"

module pid_with_deadband_filtered_derivative #(
  parameter int AlphaQ16    = pid_dbfd_pkg::ALPHA_Q16,
  parameter int DivStepBits = pid_dbfd_pkg::DIV_STEP_BITS
) (
  input  wire                                      clk_i,
  input  wire                                      rst_ni,
  input  wire                                      in_valid_i,
  output logic                                     in_stall_o,
  input  wire  pid_dbfd_pkg::in_item_t             in_item_i,
  output logic                                     out_valid_o,
  input  wire                                      out_stall_i,
  output pid_dbfd_pkg::out_item_t                  out_item_o,
  input  wire                                      psel,
  input  wire                                      penable,
  input  wire                                      pwrite,
  input  wire  [pid_dbfd_pkg::PADDR_W-1:0]         paddr,
  input  wire  [pid_dbfd_pkg::DATA_W-1:0]          pwdata,
  output logic [pid_dbfd_pkg::DATA_W-1:0]          prdata,
  output logic                                     pready
);

  localparam int DvdW      = pid_dbfd_pkg::DVD_W;
  localparam int QuotW     = pid_dbfd_pkg::QUOT_W;
  localparam int AlphaRest = pid_dbfd_pkg::Q16_ONE - AlphaQ16;
  localparam int FsumW     = 51;

  typedef enum logic [4:0] {
    ST_IDLE, ST_ERR, ST_FP, ST_FI, ST_FEND, ST_DEAD, ST_MP, ST_IDT, ST_DIVI,
    ST_WAITI, ST_ACC, ST_CLAMPI, ST_MI, ST_I, ST_WAITD, ST_F1, ST_F2, ST_F3,
    ST_F4, ST_MD, ST_D, ST_SUM, ST_CLAMPD, ST_DONE
  } state_e;

  logic signed [31:0] gain_p_q, gain_i_q, gain_d_q;
  logic signed [31:0] drive_min_q, drive_max_q, accum_min_q, accum_max_q;
  logic [30:0]        dead_zone_q;

  state_e                  state_q, state_d;
  logic                    first_q, first_d;
  logic signed [31:0]      prior_q, prior_d;
  logic signed [31:0]      integ_q, integ_d;
  logic signed [31:0]      filt_q, filt_d;
  pid_dbfd_pkg::in_item_t  item_q, item_d;
  logic signed [31:0]      err_q, err_d;
  logic signed [32:0]      diff_q, diff_d;
  logic signed [31:0]      p_q, p_d, i_q, i_d, d_q, d_d;
  logic signed [QuotW:0]   acc_q, acc_d;
  logic signed [31:0]      raw_q, raw_d;
  logic signed [FsumW-1:0] fsum_q, fsum_d;
  logic signed [33:0]      sum_q, sum_d;
  logic signed [31:0]      drive_q, drive_d;
  logic signed [65:0]      prod_q, prod_d;
  logic                    out_valid_q, out_valid_d;
  pid_dbfd_pkg::out_item_t out_q, out_d;

  logic signed [32:0]  mul_a, mul_b;
  logic                mul_en;
  logic signed [32:0]  err33, err_abs;
  logic signed [31:0]  err_sat;
  logic [15:0]         dt_w;
  logic signed [65:0]  prod_abs;
  logic                wr_en;

  pid_dbfd_pkg::div_req_t div_req;
  pid_dbfd_pkg::div_rsp_t div_rsp;

  function automatic logic signed [31:0] sat32(input logic signed [65:0] v);
    logic signed [31:0] r;
    if (v[65:31] == '0 || v[65:31] == '1) begin
      r = v[31:0];
    end else if (v[65]) begin
      r = 32'sh8000_0000;
    end else begin
      r = 32'sh7fff_ffff;
    end
    return r;
  endfunction

  function automatic logic signed [31:0] clamp32(input logic signed [65:0] v,
                                                 input logic signed [31:0] lo,
                                                 input logic signed [31:0] hi);
    logic signed [31:0] r;
    if (v < 66'(lo)) begin
      r = lo;
    end else if (v > 66'(hi)) begin
      r = hi;
    end else begin
      r = v[31:0];
    end
    return r;
  endfunction

  pid_dbfd_div #(
    .StepBits(DivStepBits)
  ) u_div (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .req_i (div_req),
    .rsp_o (div_rsp)
  );

  // Configuration registers
  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite && pready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      gain_p_q    <= '0;
      gain_i_q    <= '0;
      gain_d_q    <= '0;
      drive_min_q <= pid_dbfd_pkg::DRIVE_MIN_RST;
      drive_max_q <= pid_dbfd_pkg::DRIVE_MAX_RST;
      accum_min_q <= pid_dbfd_pkg::ACCUM_MIN_RST;
      accum_max_q <= pid_dbfd_pkg::ACCUM_MAX_RST;
      dead_zone_q <= '0;
    end else if (wr_en) begin
      unique case (pid_dbfd_pkg::reg_idx_e'(paddr[4:2]))
        pid_dbfd_pkg::REG_GAIN_P:    gain_p_q    <= pwdata;
        pid_dbfd_pkg::REG_GAIN_I:    gain_i_q    <= pwdata;
        pid_dbfd_pkg::REG_GAIN_D:    gain_d_q    <= pwdata;
        pid_dbfd_pkg::REG_DRIVE_MIN: drive_min_q <= pwdata;
        pid_dbfd_pkg::REG_DRIVE_MAX: drive_max_q <= pwdata;
        pid_dbfd_pkg::REG_ACCUM_MIN: accum_min_q <= pwdata;
        pid_dbfd_pkg::REG_ACCUM_MAX: accum_max_q <= pwdata;
        pid_dbfd_pkg::REG_DEAD_ZONE: dead_zone_q <= pwdata[30:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (pid_dbfd_pkg::reg_idx_e'(paddr[4:2]))
      pid_dbfd_pkg::REG_GAIN_P:    prdata = gain_p_q;
      pid_dbfd_pkg::REG_GAIN_I:    prdata = gain_i_q;
      pid_dbfd_pkg::REG_GAIN_D:    prdata = gain_d_q;
      pid_dbfd_pkg::REG_DRIVE_MIN: prdata = drive_min_q;
      pid_dbfd_pkg::REG_DRIVE_MAX: prdata = drive_max_q;
      pid_dbfd_pkg::REG_ACCUM_MIN: prdata = accum_min_q;
      pid_dbfd_pkg::REG_ACCUM_MAX: prdata = accum_max_q;
      pid_dbfd_pkg::REG_DEAD_ZONE: prdata = {1'b0, dead_zone_q};
      default:                     prdata = '0;
    endcase
  end

  // Datapath helpers
  assign err33    = 33'(item_q.target) - 33'(item_q.sensed);
  assign err_sat  = (err33[32] != err33[31]) ? (err33[32] ? 32'sh8000_0000 : 32'sh7fff_ffff)
                                             : err33[31:0];
  assign err_abs  = err_q[31] ? -33'(err_q) : 33'(err_q);
  assign dt_w     = (item_q.elapsed_ms == '0) ? 16'd1 : item_q.elapsed_ms;
  assign prod_abs = prod_q[65] ? -prod_q : prod_q;

  assign in_stall_o  = (state_q != ST_IDLE);
  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_q;

  always_comb begin
    state_d     = state_q;
    first_d     = first_q;
    prior_d     = prior_q;
    integ_d     = integ_q;
    filt_d      = filt_q;
    item_d      = item_q;
    err_d       = err_q;
    diff_d      = diff_q;
    p_d         = p_q;
    i_d         = i_q;
    d_d         = d_q;
    acc_d       = acc_q;
    raw_d       = raw_q;
    fsum_d      = fsum_q;
    sum_d       = sum_q;
    drive_d     = drive_q;
    out_d       = out_q;
    out_valid_d = out_valid_q && out_stall_i;
    mul_a       = '0;
    mul_b       = '0;
    mul_en      = 1'b0;
    div_req     = '0;

    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          item_d  = in_item_i;
          state_d = ST_ERR;
        end
      end
      ST_ERR: begin
        err_d = err_sat;
        if (item_q.restart) begin
          integ_d = '0;
          filt_d  = '0;
        end
        state_d = (item_q.restart || first_q) ? ST_FP : ST_DEAD;
      end
      ST_FP: begin
        mul_a   = 33'(gain_p_q);
        mul_b   = 33'(err_q);
        mul_en  = 1'b1;
        prior_d = err_q;
        filt_d  = '0;
        first_d = 1'b0;
        state_d = ST_FI;
      end
      ST_FI: begin
        p_d     = sat32(prod_q >>> 16);
        mul_a   = 33'(gain_i_q);
        mul_b   = 33'(integ_q);
        mul_en  = 1'b1;
        state_d = ST_FEND;
      end
      ST_FEND: begin
        i_d     = sat32(prod_q >>> 16);
        d_d     = '0;
        drive_d = '0;
        state_d = ST_DONE;
      end
      ST_DEAD: begin
        if ($unsigned(err_abs) < {2'b00, dead_zone_q}) begin
          err_d = '0;
        end
        state_d = ST_MP;
      end
      ST_MP: begin
        mul_a   = 33'(gain_p_q);
        mul_b   = 33'(err_q);
        mul_en  = 1'b1;
        diff_d  = 33'(err_q) - 33'(prior_q);
        state_d = ST_IDT;
      end
      ST_IDT: begin
        p_d     = sat32(prod_q >>> 16);
        mul_a   = 33'(err_q);
        mul_b   = $signed({17'b0, dt_w});
        mul_en  = 1'b1;
        state_d = ST_DIVI;
      end
      ST_DIVI: begin
        div_req.start    = 1'b1;
        div_req.neg      = prod_q[65];
        div_req.dividend = prod_abs[DvdW-1:0];
        div_req.divisor  = 16'(pid_dbfd_pkg::MS_PER_S);
        mul_a            = diff_q;
        mul_b            = 33'(pid_dbfd_pkg::MS_PER_S);
        mul_en           = 1'b1;
        prior_d          = err_q;
        state_d          = ST_WAITI;
      end
      ST_WAITI: begin
        if (!div_rsp.busy) begin
          state_d = ST_ACC;
        end
      end
      ST_ACC: begin
        acc_d            = (QuotW+1)'(integ_q) + (QuotW+1)'(div_rsp.quot);
        div_req.start    = 1'b1;
        div_req.neg      = prod_q[65];
        div_req.dividend = prod_abs[DvdW-1:0];
        div_req.divisor  = dt_w;
        state_d          = ST_CLAMPI;
      end
      ST_CLAMPI: begin
        integ_d = clamp32(66'(acc_q), accum_min_q, accum_max_q);
        state_d = ST_MI;
      end
      ST_MI: begin
        mul_a   = 33'(gain_i_q);
        mul_b   = 33'(integ_q);
        mul_en  = 1'b1;
        state_d = ST_I;
      end
      ST_I: begin
        i_d     = sat32(prod_q >>> 16);
        state_d = ST_WAITD;
      end
      ST_WAITD: begin
        if (!div_rsp.busy) begin
          raw_d   = sat32(66'(div_rsp.quot));
          state_d = ST_F1;
        end
      end
      ST_F1: begin
        mul_a   = $signed(33'(AlphaQ16));
        mul_b   = 33'(raw_q);
        mul_en  = 1'b1;
        state_d = ST_F2;
      end
      ST_F2: begin
        fsum_d  = prod_q[FsumW-1:0];
        mul_a   = $signed(33'(AlphaRest));
        mul_b   = 33'(filt_q);
        mul_en  = 1'b1;
        state_d = ST_F3;
      end
      ST_F3: begin
        fsum_d  = fsum_q + prod_q[FsumW-1:0];
        state_d = ST_F4;
      end
      ST_F4: begin
        filt_d  = sat32(66'(fsum_q >>> 16));
        state_d = ST_MD;
      end
      ST_MD: begin
        mul_a   = 33'(gain_d_q);
        mul_b   = 33'(filt_q);
        mul_en  = 1'b1;
        state_d = ST_D;
      end
      ST_D: begin
        d_d     = sat32(prod_q >>> 16);
        state_d = ST_SUM;
      end
      ST_SUM: begin
        sum_d   = 34'(p_q) + 34'(i_q) + 34'(d_q);
        state_d = ST_CLAMPD;
      end
      ST_CLAMPD: begin
        drive_d = clamp32(66'(sum_q), drive_min_q, drive_max_q);
        state_d = ST_DONE;
      end
      ST_DONE: begin
        if (!out_valid_q || !out_stall_i) begin
          out_valid_d    = 1'b1;
          out_d.drive    = drive_q;
          out_d.p_part   = p_q;
          out_d.i_part   = i_q;
          out_d.d_part   = d_q;
          out_d.last_err = prior_q;
          state_d        = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  assign prod_d = mul_en ? (66'(mul_a) * 66'(mul_b)) : prod_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      first_q     <= 1'b1;
      prior_q     <= '0;
      integ_q     <= '0;
      filt_q      <= '0;
      item_q      <= '0;
      err_q       <= '0;
      diff_q      <= '0;
      p_q         <= '0;
      i_q         <= '0;
      d_q         <= '0;
      acc_q       <= '0;
      raw_q       <= '0;
      fsum_q      <= '0;
      sum_q       <= '0;
      drive_q     <= '0;
      prod_q      <= '0;
      out_valid_q <= 1'b0;
      out_q       <= '0;
    end else begin
      state_q     <= state_d;
      first_q     <= first_d;
      prior_q     <= prior_d;
      integ_q     <= integ_d;
      filt_q      <= filt_d;
      item_q      <= item_d;
      err_q       <= err_d;
      diff_q      <= diff_d;
      p_q         <= p_d;
      i_q         <= i_d;
      d_q         <= d_d;
      acc_q       <= acc_d;
      raw_q       <= raw_d;
      fsum_q      <= fsum_d;
      sum_q       <= sum_d;
      drive_q     <= drive_d;
      prod_q      <= prod_d;
      out_valid_q <= out_valid_d;
      out_q       <= out_d;
    end
  end

  `PID_DBFD_ASSERT(a_accept_busy, clk_i, rst_ni, (in_valid_i && !in_stall_o) |=> in_stall_o,
                   "controller free right after taking an item")
  `PID_DBFD_ASSERT(a_div_start_free, clk_i, rst_ni, div_req.start |-> !div_rsp.busy,
                   "divider started while busy")
  `PID_DBFD_ASSERT(a_first_cleared, clk_i, rst_ni, $rose(out_valid_o) |-> !first_q,
                   "result delivered with first item still pending")
  `PID_DBFD_ASSERT(a_wait_div, clk_i, rst_ni,
                   (state_q == ST_WAITI && div_rsp.busy) |=> (state_q == ST_WAITI),
                   "left divider wait while divider busy")

endmodule

`default_nettype wire

// ----- rtl/pid_dbfd_div.sv -----
// Iterative unsigned divider with sign fixup, StepBits quotient bits per cycle.
// Depends on pid_dbfd_pkg and the block's assertion macros.
`default_nettype none
`include "pid_with_deadband_filtered_derivative_macros.svh"

module pid_dbfd_div #(
  parameter int StepBits = pid_dbfd_pkg::DIV_STEP_BITS
) (
  input  wire                         clk_i,
  input  wire                         rst_ni,
  input  wire pid_dbfd_pkg::div_req_t req_i,
  output pid_dbfd_pkg::div_rsp_t      rsp_o
);

  localparam int DvdW  = pid_dbfd_pkg::DVD_W;
  localparam int DvsW  = pid_dbfd_pkg::DVS_W;
  localparam int QuotW = pid_dbfd_pkg::QUOT_W;
  localparam int Steps = (DvdW + StepBits - 1) / StepBits;
  localparam int PadW  = Steps * StepBits;
  localparam int CntW  = $clog2(Steps + 1);

  logic            busy_q, busy_d;
  logic            neg_q, neg_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic [DvsW-1:0] dvs_q, dvs_d;
  logic [DvsW-1:0] rem_q, rem_d;
  logic [PadW-1:0] quo_q, quo_d;

  logic [DvsW-1:0] rem_w;
  logic [DvsW:0]   trial;
  logic [PadW-1:0] quo_w;
  logic [QuotW-1:0] mag;

  always_comb begin
    rem_w = rem_q;
    quo_w = quo_q;
    trial = '0;
    for (int k = 0; k < StepBits; k++) begin
      trial = {rem_w, quo_w[PadW-1]};
      quo_w = {quo_w[PadW-2:0], 1'b0};
      if (trial >= {1'b0, dvs_q}) begin
        trial    = trial - {1'b0, dvs_q};
        quo_w[0] = 1'b1;
      end
      rem_w = trial[DvsW-1:0];
    end
  end

  always_comb begin
    busy_d = busy_q;
    neg_d  = neg_q;
    cnt_d  = cnt_q;
    dvs_d  = dvs_q;
    rem_d  = rem_q;
    quo_d  = quo_q;
    if (busy_q) begin
      rem_d = rem_w;
      quo_d = quo_w;
      cnt_d = cnt_q - CntW'(1);
      if (cnt_q == '0) begin
        busy_d = 1'b0;
      end
    end else if (req_i.start) begin
      busy_d = 1'b1;
      neg_d  = req_i.neg;
      cnt_d  = CntW'(Steps - 1);
      dvs_d  = req_i.divisor;
      rem_d  = '0;
      quo_d  = PadW'(req_i.dividend);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      neg_q  <= 1'b0;
      cnt_q  <= '0;
      dvs_q  <= '0;
      rem_q  <= '0;
      quo_q  <= '0;
    end else begin
      busy_q <= busy_d;
      neg_q  <= neg_d;
      cnt_q  <= cnt_d;
      dvs_q  <= dvs_d;
      rem_q  <= rem_d;
      quo_q  <= quo_d;
    end
  end

  assign mag        = {1'b0, quo_q[DvdW-1:0]};
  assign rsp_o.busy = busy_q;
  assign rsp_o.quot = neg_q ? $signed(-mag) : $signed(mag);

  `PID_DBFD_ASSERT(a_div_run_holds, clk_i, rst_ni, (busy_q && cnt_q != '0) |=> busy_q,
                   "divider stopped before its last step")
  `PID_DBFD_ASSERT(a_div_ends_on_last, clk_i, rst_ni, $fell(busy_q) |-> ($past(cnt_q) == '0),
                   "divider ended early")
  `PID_DBFD_ASSERT(a_div_loads, clk_i, rst_ni,
                   (req_i.start && !busy_q) |=> (busy_q && cnt_q == CntW'(Steps - 1)),
                   "divider did not load on start")

endmodule

`default_nettype wire

// ----- tb/sv/tb.sv -----
// Self-checking testbench for pid_with_deadband_filtered_derivative.
// Drives items over valid/stall and configures over APB; predicts each result in a scoreboard.
// Depends on pid_dbfd_pkg and the block's RTL only.
`default_nettype none

module tb;
  import pid_dbfd_pkg::*;

  class pid_drive_scoreboard;
    int kp, ki, kd;
    int drive_lo, drive_hi, integ_lo, integ_hi, deadband;
    bit awaiting_first;
    int prev_err, integ, deriv_lp;
    out_item_t expected_drives[$];
    int errors;
    int checked;

    function new();
      kp = 0;
      ki = 0;
      kd = 0;
      drive_lo = DRIVE_MIN_RST;
      drive_hi = DRIVE_MAX_RST;
      integ_lo = ACCUM_MIN_RST;
      integ_hi = ACCUM_MAX_RST;
      deadband = 0;
      awaiting_first = 1'b1;
      prev_err = 0;
      integ = 0;
      deriv_lp = 0;
      errors = 0;
      checked = 0;
    endfunction

    function void set_reg(reg_idx_e idx, logic [31:0] val);
      case (idx)
        REG_GAIN_P:    kp = val;
        REG_GAIN_I:    ki = val;
        REG_GAIN_D:    kd = val;
        REG_DRIVE_MIN: drive_lo = val;
        REG_DRIVE_MAX: drive_hi = val;
        REG_ACCUM_MIN: integ_lo = val;
        REG_ACCUM_MAX: integ_hi = val;
        REG_DEAD_ZONE: deadband = {1'b0, val[30:0]};
        default: ;
      endcase
    endfunction

    function int sat32(longint v);
      if (v > 64'sd2147483647) return 32'sh7fffffff;
      if (v < -64'sd2147483648) return 32'sh80000000;
      return int'(v);
    endfunction

    function longint clamp(longint v, longint lo, longint hi);
      if (v < lo) return lo;
      if (v > hi) return hi;
      return v;
    endfunction

    function int gain_term(int g, int x);
      longint prod;
      prod = longint'(g) * longint'(x);
      return sat32(prod >>> 16);
    endfunction

    function out_item_t predict_drive(in_item_t it);
      out_item_t r;
      longint dt, mag, acc, raw, filt, drv;
      int err, p, i, d;
      err = sat32(longint'(it.target) - longint'(it.sensed));
      dt = longint'(it.elapsed_ms);
      if (dt == 0) dt = 1;
      drv = 0;
      if (it.restart) begin
        integ = 0;
        deriv_lp = 0;
        awaiting_first = 1'b1;
      end
      if (awaiting_first) begin
        prev_err = err;
        deriv_lp = 0;
        awaiting_first = 1'b0;
      end else begin
        mag = (err < 0) ? -longint'(err) : longint'(err);
        if (mag < longint'(deadband)) err = 0;
        p = gain_term(kp, err);
        acc = longint'(integ) + (longint'(err) * dt) / 1000;
        integ = int'(clamp(acc, integ_lo, integ_hi));
        i = gain_term(ki, integ);
        raw = sat32(((longint'(err) - longint'(prev_err)) * 1000) / dt);
        filt = longint'(ALPHA_Q16) * raw
             + (longint'(Q16_ONE) - longint'(ALPHA_Q16)) * longint'(deriv_lp);
        deriv_lp = sat32(filt >>> 16);
        d = gain_term(kd, deriv_lp);
        drv = clamp(longint'(p) + longint'(i) + longint'(d), drive_lo, drive_hi);
        prev_err = err;
      end
      r.drive = drv[31:0];
      r.p_part = gain_term(kp, prev_err);
      r.i_part = gain_term(ki, integ);
      r.d_part = gain_term(kd, deriv_lp);
      r.last_err = prev_err;
      return r;
    endfunction

    function void note_sample(in_item_t it);
      expected_drives.push_back(predict_drive(it));
    endfunction

    function int pending();
      return expected_drives.size();
    endfunction

    function void cmp_field(string name, logic signed [31:0] exp_v, logic signed [31:0] act_v);
      if (act_v !== exp_v) begin
        errors++;
        $display("%0t: %s mismatch, expected %0d (%h) got %0d (%h)",
                 $time, name, exp_v, exp_v, act_v, act_v);
      end
    endfunction

    function void check_drive(out_item_t got);
      out_item_t exp_r;
      if (expected_drives.size() == 0) begin
        errors++;
        $display("%0t: unexpected result, expected none got drive %0d",
                 $time, got.drive);
        return;
      end
      exp_r = expected_drives.pop_front();
      checked++;
      cmp_field("drive", exp_r.drive, got.drive);
      cmp_field("p_part", exp_r.p_part, got.p_part);
      cmp_field("i_part", exp_r.i_part, got.i_part);
      cmp_field("d_part", exp_r.d_part, got.d_part);
      cmp_field("last_err", exp_r.last_err, got.last_err);
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  in_item_t in_item = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  out_item_t out_item;
  logic psel = 1'b0;
  logic penable = 1'b0;
  logic pwrite = 1'b0;
  logic [PADDR_W-1:0] paddr = '0;
  logic [DATA_W-1:0] pwdata = '0;
  logic [DATA_W-1:0] prdata;
  logic pready;

  pid_drive_scoreboard sb;
  bit tx_idle_en = 1'b1;
  bit rx_idle_en = 1'b1;
  bit hold_req = 1'b0;
  bit hold_done = 1'b0;
  int n_sent = 0;
  int n_cfg = 0;

  pid_with_deadband_filtered_derivative DUT (
    .clk_i      (clk),
    .rst_ni     (rst_n),
    .in_valid_i (in_valid),
    .in_stall_o (in_stall),
    .in_item_i  (in_item),
    .out_valid_o(out_valid),
    .out_stall_i(out_stall),
    .out_item_o (out_item),
    .psel       (psel),
    .penable    (penable),
    .pwrite     (pwrite),
    .paddr      (paddr),
    .pwdata     (pwdata),
    .prdata     (prdata),
    .pready     (pready)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) sb.check_drive(out_item);
  end

  initial begin
    wait (rst_n);
    forever begin
      @(posedge clk);
      if (hold_req && !hold_done) begin
        out_stall <= 1'b1;
        repeat (400) @(posedge clk);
        hold_done = 1'b1;
        out_stall <= 1'b0;
      end else if (rx_idle_en && $urandom_range(0, 5) == 0) begin
        out_stall <= 1'b1;
        repeat ($urandom_range(1, 13)) @(posedge clk);
        out_stall <= 1'b0;
      end
    end
  end

  initial begin
    #5_000_000;
    $display("Some tests failed");
    $finish;
  end

  task automatic write_reg(input reg_idx_e idx, input logic [31:0] val);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= PADDR_W'(idx) << 2;
    pwdata <= val;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    sb.set_reg(idx, val);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
  endtask

  task automatic set_config(input int gp, input int gi, input int gd, input int dlo,
                            input int dhi, input int alo, input int ahi, input int dz);
    write_reg(REG_GAIN_P, gp);
    write_reg(REG_GAIN_I, gi);
    write_reg(REG_GAIN_D, gd);
    write_reg(REG_DRIVE_MIN, dlo);
    write_reg(REG_DRIVE_MAX, dhi);
    write_reg(REG_ACCUM_MIN, alo);
    write_reg(REG_ACCUM_MAX, ahi);
    write_reg(REG_DEAD_ZONE, dz);
    n_cfg++;
  endtask

  function automatic int rand_gain();
    case ($urandom_range(0, 7))
      0: return 32'sh7fffffff;
      1: return 32'sh80000000;
      2: return $urandom;
      default: return int'($urandom_range(0, 524288)) - 262144;
    endcase
  endfunction

  task automatic random_config();
    int dlo, dhi, alo, ahi, dz;
    case ($urandom_range(0, 5))
      0: begin
        dlo = 32'sh80000000;
        dhi = 32'sh7fffffff;
      end
      1: begin
        dlo = $urandom;
        dhi = $urandom;
      end
      default: begin
        dhi = int'($urandom_range(1, 500)) * Q16_ONE;
        dlo = -int'($urandom_range(1, 500)) * Q16_ONE;
      end
    endcase
    case ($urandom_range(0, 5))
      0: begin
        alo = 32'sh80000000;
        ahi = 32'sh7fffffff;
      end
      1: begin
        alo = $urandom;
        ahi = $urandom;
      end
      default: begin
        ahi = int'($urandom_range(1, 300)) * Q16_ONE;
        alo = -int'($urandom_range(1, 300)) * Q16_ONE;
      end
    endcase
    case ($urandom_range(0, 3))
      0: dz = 0;
      1: dz = $urandom;
      default: dz = $urandom_range(0, 2 * Q16_ONE);
    endcase
    set_config(rand_gain(), rand_gain(), rand_gain(), dlo, dhi, alo, ahi, dz);
  endtask

  function automatic in_item_t mk(input int tg, input int sn, input int dt, input bit rs);
    in_item_t it;
    it.target = tg;
    it.sensed = sn;
    it.elapsed_ms = dt[15:0];
    it.restart = rs;
    return it;
  endfunction

  function automatic in_item_t rand_sample();
    in_item_t it;
    int sn, e;
    case ($urandom_range(0, 9))
      0: begin
        it.target = $urandom;
        it.sensed = $urandom;
      end
      1: begin
        it.target = ($urandom_range(0, 1)) ? 32'sh7fffffff : 32'sh80000000;
        it.sensed = ($urandom_range(0, 2) == 0) ? 0 :
                    ($urandom_range(0, 1)) ? 32'sh7fffffff : 32'sh80000000;
      end
      default: begin
        sn = int'($urandom_range(0, 200 * Q16_ONE)) - 100 * Q16_ONE;
        if ($urandom_range(0, 4) == 0)
          e = int'($urandom_range(0, 2 * Q16_ONE)) - Q16_ONE;
        else
          e = int'($urandom_range(0, 40 * Q16_ONE)) - 20 * Q16_ONE;
        it.sensed = sn;
        it.target = sn + e;
      end
    endcase
    case ($urandom_range(0, 9))
      0: it.elapsed_ms = 16'd0;
      1: it.elapsed_ms = 16'hffff;
      2: it.elapsed_ms = $urandom_range(0, 65535);
      default: it.elapsed_ms = $urandom_range(1, 50);
    endcase
    it.restart = ($urandom_range(0, 39) == 0);
    return it;
  endfunction

  task automatic send_sample(input in_item_t it);
    if (tx_idle_en && $urandom_range(0, 5) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 13)) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_item <= it;
    do @(posedge clk); while (in_stall);
    sb.note_sample(it);
    n_sent++;
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
  endtask

  task automatic random_config_idle();
    drain();
    random_config();
  endtask

  initial begin
    sb = new();
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    set_config(2 * Q16_ONE, Q16_ONE / 2, Q16_ONE / 4, DRIVE_MIN_RST, DRIVE_MAX_RST,
               ACCUM_MIN_RST, ACCUM_MAX_RST, Q16_ONE / 2);
    send_sample(mk(10 * Q16_ONE, 4 * Q16_ONE, 10, 1'b0));
    send_sample(mk(10 * Q16_ONE, 5 * Q16_ONE, 10, 1'b0));
    send_sample(mk(3 * Q16_ONE, 5 * Q16_ONE, 0, 1'b0));
    send_sample(mk(Q16_ONE + 100, Q16_ONE, 65535, 1'b0));
    send_sample(mk(Q16_ONE / 2, 0, 20, 1'b0));
    send_sample(mk(32'sh7fffffff, 32'sh80000000, 65535, 1'b0));
    send_sample(mk(32'sh80000000, 32'sh7fffffff, 65535, 1'b0));
    send_sample(mk(32'sh80000000, 0, 1, 1'b0));
    send_sample(mk(0, 32'sh80000000, 1, 1'b0));
    send_sample(mk(7 * Q16_ONE, Q16_ONE, 5, 1'b1));
    send_sample(mk(6 * Q16_ONE, Q16_ONE, 5, 1'b0));
    send_sample(mk(-3 * Q16_ONE, Q16_ONE, 8, 1'b1));
    send_sample(mk(-2 * Q16_ONE, Q16_ONE, 8, 1'b1));
    send_sample(mk(-Q16_ONE, Q16_ONE, 1, 1'b0));
    drain();

    set_config(4 * Q16_ONE, 2 * Q16_ONE, Q16_ONE, 50 * Q16_ONE, -50 * Q16_ONE,
               10 * Q16_ONE, -10 * Q16_ONE, 0);
    send_sample(mk(5 * Q16_ONE, 0, 100, 1'b1));
    send_sample(mk(90 * Q16_ONE, 0, 1000, 1'b0));
    send_sample(mk(-90 * Q16_ONE, 0, 1000, 1'b0));
    send_sample(mk(0, 0, 1000, 1'b0));
    drain();

    set_config(32'sh7fffffff, 32'sh80000000, 32'sh7fffffff, 32'sh80000000, 32'sh7fffffff,
               32'sh80000000, 32'sh7fffffff, 0);
    send_sample(mk(Q16_ONE, 0, 1, 1'b1));
    send_sample(mk(32'sh7fffffff, 32'sh80000000, 65535, 1'b0));
    send_sample(mk(32'sh80000000, 32'sh7fffffff, 1, 1'b0));
    send_sample(mk(-5, 3, 0, 1'b0));
    drain();

    for (int ph = 0; ph < 6; ph++) begin
      drain();
      case (ph)
        0: set_config(32'sh7fffffff, 32'sh7fffffff, 32'sh80000000, 32'sh80000000,
                      32'sh7fffffff, 32'sh80000000, 32'sh7fffffff, 32'hffffffff);
        1: set_config(Q16_ONE, Q16_ONE / 8, Q16_ONE / 16, DRIVE_MIN_RST, DRIVE_MAX_RST,
                      ACCUM_MIN_RST, ACCUM_MAX_RST, Q16_ONE / 4);
        default: random_config();
      endcase
      if (ph == 5) begin
        tx_idle_en = 1'b0;
        rx_idle_en = 1'b0;
      end
      for (int k = 0; k < 160; k++) begin
        if (ph == 2 && k == 20) hold_req = 1'b1;
        if (ph == 3 && k == 80) drain();
        if (ph < 5 && $urandom_range(0, 39) == 0) tx_idle_en = !tx_idle_en;
        if (ph < 5 && $urandom_range(0, 39) == 0) rx_idle_en = !rx_idle_en;
        if (ph < 5 && k % 40 == 39 && $urandom_range(0, 3) == 0) random_config_idle();
        send_sample(rand_sample());
      end
    end

    drain();
    repeat (100) @(posedge clk);
    $display("Run covered %0d items in %0d configuration settings, %0d results checked.",
             n_sent, n_cfg, sb.checked);
    $display("Included saturated errors, crossed clamps, restarts and a long output hold.");
    if (sb.errors == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

`default_nettype wire
